// ----- sv/pressure_sensor_compensation_defines.svh -----
// assertion macros shared by the compensation pipeline modules
`ifndef PRESSURE_SENSOR_COMPENSATION_DEFINES_SVH
`define PRESSURE_SENSOR_COMPENSATION_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define PSC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define PSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/psc_pkg.sv -----
// shared widths, types and constants of the pressure compensation block
`timescale 1ns / 1ps
`default_nettype none

package psc_pkg;

  localparam int CAL_W     = 16;
  localparam int RAW_W     = 24;
  localparam int TEMP_W    = 19;
  localparam int PRES_W    = 22;
  localparam int CFG_IDX_W = 3;

  localparam int REF_SHIFT  = 8;
  localparam int T_SHIFT    = 23;
  localparam int OFF_SCALE  = 16;
  localparam int OFF_SHIFT  = 7;
  localparam int SENS_SCALE = 15;
  localparam int SENS_SHIFT = 8;
  localparam int P_SHIFT1   = 21;
  localparam int P_SHIFT2   = 15;
  localparam int SPLIT_W    = 17;

  localparam int TEMP_BASE = 2000;
  localparam int TEMP_MIN  = -131072;
  localparam int TEMP_MAX  = 135167;
  localparam int PRES_MIN  = -2097152;
  localparam int PRES_MAX  = 2097151;

  localparam int DT_W     = RAW_W + 1;
  localparam int PROD_W   = DT_W + CAL_W + 1;
  localparam int TSUM_W   = TEMP_W + 1;
  localparam int OFF_W    = 36;
  localparam int SENS_W   = 35;
  localparam int HI_W     = SENS_W - SPLIT_W;
  localparam int PLO_W    = RAW_W + SPLIT_W;
  localparam int PHI_W    = RAW_W + 1 + HI_W;
  localparam int FULL_W   = PHI_W + SPLIT_W;
  localparam int DIFF_W   = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    IDX_PRES_SENS = 3'd0,
    IDX_PRES_OFF  = 3'd1,
    IDX_SENS_TC   = 3'd2,
    IDX_OFF_TC    = 3'd3,
    IDX_TEMP_REF  = 3'd4,
    IDX_TEMP_TC   = 3'd5
  } cal_idx_t;

  typedef struct packed {
    logic [CAL_W-1:0] pres_sens;
    logic [CAL_W-1:0] pres_off;
    logic [CAL_W-1:0] sens_tc;
    logic [CAL_W-1:0] off_tc;
    logic [CAL_W-1:0] temp_ref;
    logic [CAL_W-1:0] temp_tc;
  } cal_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
    logic [RAW_W-1:0]         raw_p;
  } mid_t;

endpackage

`default_nettype wire

// ----- sv/psc_if.sv -----
// item channels of the pressure compensation block
`timescale 1ns / 1ps
`default_nettype none

interface psc_in_if
  import psc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_temperature;
  logic [RAW_W-1:0] raw_pressure;

  modport source (output valid, output raw_temperature, output raw_pressure, input ready);
  modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface psc_out_if
  import psc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature;
  logic signed [PRES_W-1:0] pressure;

  modport source (output valid, output temperature, output pressure, input ready);
  modport sink   (input valid, input temperature, input pressure, output ready);
endinterface

interface psc_cfg_if
  import psc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CAL_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/psc_cal_regs.sv -----
// calibration word registers written through the configuration channel
`timescale 1ns / 1ps
`default_nettype none

module psc_cal_regs
  import psc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  psc_cfg_if.sink  cfg_ch,
  output cal_t     cal
);

  cal_t cal_r, cal_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cal          = cal_r;

  always_comb begin
    cal_nxt = cal_r;
    if (cfg_ch.valid) begin
      case (cal_idx_t'(cfg_ch.index))
        IDX_PRES_SENS: cal_nxt.pres_sens = cfg_ch.data;
        IDX_PRES_OFF:  cal_nxt.pres_off  = cfg_ch.data;
        IDX_SENS_TC:   cal_nxt.sens_tc   = cfg_ch.data;
        IDX_OFF_TC:    cal_nxt.off_tc    = cfg_ch.data;
        IDX_TEMP_REF:  cal_nxt.temp_ref  = cfg_ch.data;
        IDX_TEMP_TC:   cal_nxt.temp_tc   = cfg_ch.data;
        default:       cal_nxt = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/psc_terms.sv -----
// first three stages: temperature difference, coefficient products, temp/off/sens
`timescale 1ns / 1ps
`default_nettype none
`include "pressure_sensor_compensation_defines.svh"

module psc_terms
  import psc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cal_t    cal,
  psc_in_if.sink  in_ch,
  output logic    mid_valid,
  input  logic    mid_ready,
  output mid_t    mid
);

  localparam logic signed [TSUM_W-1:0] TSUM_LO = TSUM_W'(TEMP_MIN);
  localparam logic signed [TSUM_W-1:0] TSUM_HI = TSUM_W'(TEMP_MAX);

  logic [2:0] v_r, v_nxt, en;

  // stage 1
  logic [DT_W-1:0]        ref_scaled;
  logic signed [DT_W-1:0] dt_r, dt_nxt;
  logic [RAW_W-1:0]       d1a_r;

  // stage 2
  logic signed [PROD_W-1:0] pt_r, pt_nxt, po_r, po_nxt, ps_r, ps_nxt;
  logic [RAW_W-1:0]         d1b_r;

  // stage 3
  logic signed [PROD_W-1:0] t_shift, o_shift, s_shift;
  logic signed [TSUM_W-1:0] temp_sum;
  logic signed [TEMP_W-1:0] temp_r, temp_nxt;
  logic signed [OFF_W-1:0]  off_r, off_nxt;
  logic signed [SENS_W-1:0] sens_r, sens_nxt;
  logic [RAW_W-1:0]         d1c_r;

  assign en[2]       = !v_r[2] || mid_ready;
  assign en[1]       = !v_r[1] || en[2];
  assign en[0]       = !v_r[0] || en[1];
  assign in_ch.ready = en[0];

  assign v_nxt[0] = en[0] ? in_ch.valid : v_r[0];
  assign v_nxt[1] = en[1] ? v_r[0]      : v_r[1];
  assign v_nxt[2] = en[2] ? v_r[1]      : v_r[2];

  assign ref_scaled = DT_W'(cal.temp_ref) << REF_SHIFT;
  assign dt_nxt     = $signed(DT_W'(in_ch.raw_temperature)) - $signed(ref_scaled);

  assign pt_nxt = dt_r * $signed({1'b0, cal.temp_tc});
  assign po_nxt = dt_r * $signed({1'b0, cal.off_tc});
  assign ps_nxt = dt_r * $signed({1'b0, cal.sens_tc});

  assign t_shift  = pt_r >>> T_SHIFT;
  assign o_shift  = po_r >>> OFF_SHIFT;
  assign s_shift  = ps_r >>> SENS_SHIFT;
  assign temp_sum = $signed(t_shift[TSUM_W-1:0]) + $signed(TSUM_W'(TEMP_BASE));
  assign off_nxt  = $signed(o_shift[OFF_W-1:0])
                  + $signed(OFF_W'(cal.pres_off) << OFF_SCALE);
  assign sens_nxt = $signed(s_shift[SENS_W-1:0])
                  + $signed(SENS_W'(cal.pres_sens) << SENS_SCALE);

  always_comb begin
    if (temp_sum < TSUM_LO) begin
      temp_nxt = TEMP_W'(TEMP_MIN);
    end else if (temp_sum > TSUM_HI) begin
      temp_nxt = TEMP_W'(TEMP_MAX);
    end else begin
      temp_nxt = temp_sum[TEMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dt_r  <= dt_nxt;
      d1a_r <= in_ch.raw_pressure;
    end
    if (en[1]) begin
      pt_r  <= pt_nxt;
      po_r  <= po_nxt;
      ps_r  <= ps_nxt;
      d1b_r <= d1a_r;
    end
    if (en[2]) begin
      temp_r <= temp_nxt;
      off_r  <= off_nxt;
      sens_r <= sens_nxt;
      d1c_r  <= d1b_r;
    end
  end

  assign mid_valid = v_r[2];

  always_comb begin
    mid.temp  = temp_r;
    mid.off   = off_r;
    mid.sens  = sens_r;
    mid.raw_p = d1c_r;
  end

  `PSC_ASSERT_SAME(a_terms_full_when_blocked, !in_ch.ready, &v_r,
    "input blocked while a stage is empty")
  `PSC_ASSERT_NEXT(a_terms_accept_enters, in_ch.valid && in_ch.ready, v_r[0],
    "accepted item did not enter the first stage")
  `PSC_ASSERT_NEXT(a_terms_stall_holds, v_r[2] && !mid_ready,
    v_r[2] && $stable(sens_r) && $stable(off_r) && $stable(temp_r),
    "stalled item changed or vanished")

endmodule

`default_nettype wire

// ----- sv/psc_press.sv -----
// last three stages: split sensitivity product, recombination, offset and clamp
`timescale 1ns / 1ps
`default_nettype none
`include "pressure_sensor_compensation_defines.svh"

module psc_press
  import psc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      mid_valid,
  output logic      mid_ready,
  input  mid_t      mid,
  psc_out_if.source out_ch
);

  localparam logic signed [DIFF_W-1:0] PRES_LO = DIFF_W'(PRES_MIN);
  localparam logic signed [DIFF_W-1:0] PRES_HI = DIFF_W'(PRES_MAX);

  logic [2:0] v_r, v_nxt, en;

  // stage 4
  logic [PLO_W-1:0]         plo_r, plo_nxt;
  logic signed [PHI_W-1:0]  phi_r, phi_nxt;
  logic signed [OFF_W-1:0]  off4_r;
  logic signed [TEMP_W-1:0] temp4_r;

  // stage 5
  logic signed [FULL_W-1:0] phi_ext, plo_ext;
  logic signed [FULL_W-1:0] full_r, full_nxt;
  logic signed [OFF_W-1:0]  off5_r;
  logic signed [TEMP_W-1:0] temp5_r;

  // stage 6
  logic signed [FULL_W-1:0] full_sh;
  logic signed [DIFF_W-1:0] diff, diff_sh;
  logic signed [PRES_W-1:0] pres_r, pres_nxt;
  logic signed [TEMP_W-1:0] temp6_r;

  assign en[2]     = !v_r[2] || out_ch.ready;
  assign en[1]     = !v_r[1] || en[2];
  assign en[0]     = !v_r[0] || en[1];
  assign mid_ready = en[0];

  assign v_nxt[0] = en[0] ? mid_valid : v_r[0];
  assign v_nxt[1] = en[1] ? v_r[0]    : v_r[1];
  assign v_nxt[2] = en[2] ? v_r[1]    : v_r[2];

  assign plo_nxt = mid.raw_p * mid.sens[SPLIT_W-1:0];
  assign phi_nxt = $signed({1'b0, mid.raw_p}) * $signed(mid.sens[SENS_W-1:SPLIT_W]);

  assign phi_ext  = FULL_W'(phi_r);
  assign plo_ext  = $signed(FULL_W'(plo_r));
  assign full_nxt = (phi_ext <<< SPLIT_W) + plo_ext;

  assign full_sh = full_r >>> P_SHIFT1;
  assign diff    = $signed(full_sh[DIFF_W-1:0]) - DIFF_W'(off5_r);
  assign diff_sh = diff >>> P_SHIFT2;

  always_comb begin
    if (diff_sh < PRES_LO) begin
      pres_nxt = PRES_W'(PRES_MIN);
    end else if (diff_sh > PRES_HI) begin
      pres_nxt = PRES_W'(PRES_MAX);
    end else begin
      pres_nxt = diff_sh[PRES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      plo_r   <= plo_nxt;
      phi_r   <= phi_nxt;
      off4_r  <= mid.off;
      temp4_r <= mid.temp;
    end
    if (en[1]) begin
      full_r  <= full_nxt;
      off5_r  <= off4_r;
      temp5_r <= temp4_r;
    end
    if (en[2]) begin
      pres_r  <= pres_nxt;
      temp6_r <= temp5_r;
    end
  end

  assign out_ch.valid       = v_r[2];
  assign out_ch.temperature = temp6_r;
  assign out_ch.pressure    = pres_r;

  `PSC_ASSERT_SAME(a_press_full_when_blocked, !mid_ready, &v_r,
    "pressure stages blocked while a stage is empty")
  `PSC_ASSERT_NEXT(a_press_accept_enters, mid_valid && mid_ready, v_r[0],
    "item from the term stages was lost")
  `PSC_ASSERT_NEXT(a_press_product_holds, v_r[0] && !en[1],
    v_r[0] && $stable(plo_r) && $stable(phi_r),
    "stalled partial products changed")

endmodule

`default_nettype wire

// ----- sv/pressure_sensor_compensation.sv -----
// top level of the first-order pressure and temperature compensation pipeline
// Usage:
//   in_ch  carries one pair of raw 24-bit readings (temperature, pressure) per item.
//   out_ch returns one item per input item: compensated temperature in
//          hundredths of a degree and compensated pressure, both clamped.
//   cfg_ch writes the six 16-bit calibration words by index 0..5; other
//          indexes are ignored. cfg_ch is always ready. Write only while the
//          pipeline is empty.
// Throughput: one item per cycle while out_ch.ready is high; six register stages,
//   the widest step being the 60-bit sensitivity product, split at bit 17 of the
//   sensitivity into two partial products over one stage and recombined in the next.
// Reset (rst_n low at a clock edge) empties every stage and clears the
//   calibration words to zero.
// When the receiver holds out_ch.ready low the output item stays put; earlier
//   stages keep filling their empty slots, and in_ch.ready drops only once
//   all six stages hold items.
`timescale 1ns / 1ps
`default_nettype none

module pressure_sensor_compensation
  import psc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  psc_in_if.sink    in_ch,
  psc_out_if.source out_ch,
  psc_cfg_if.sink   cfg_ch
);

  cal_t cal;
  logic mid_valid;
  logic mid_ready;
  mid_t mid;

  psc_cal_regs u_cal_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cal    (cal)
  );

  psc_terms u_terms (
    .clk       (clk),
    .rst_n     (rst_n),
    .cal       (cal),
    .in_ch     (in_ch),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid       (mid)
  );

  psc_press u_press (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid       (mid),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
